// ===== hw/rtl/pgth_pkg.sv =====
// shared types and constants for the procedural grid texture hit block
package pgth_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int REG_WIDTH           = 48;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int DOT_FRAC_BITS       = 24;
    localparam int QUOT_WIDTH          = DOT_FRAC_BITS + 1;
    localparam int SQ_WIDTH            = 2 * QUOT_WIDTH;
    localparam int SUM_WIDTH           = SQ_WIDTH + 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_GRID_MODE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_AXIS_X    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_AXIS_Y    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_AXIS_Z    = 3'd3;

    typedef enum logic [1:0] {
        MODE_PLANE = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_CUBE  = 2'd2,
        MODE_DOT   = 2'd3
    } grid_mode_t;

    typedef struct packed {
        logic                hit;
        logic [SQ_WIDTH-1:0] sq;
    } lane_res_t;

endpackage

// ===== hw/rtl/pgth_lane.sv =====
// one axis lane: pipelined modulo, distance test and pipelined ratio divide for the dot test
module pgth_lane #(
    parameter int COORD_WIDTH     = pgth_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = pgth_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [pgth_pkg::REG_WIDTH-1:0]      axis_cfg,
    input  logic signed [COORD_WIDTH-1:0]       coord,
    output pgth_pkg::lane_res_t                 res
);

    localparam int K   = COORD_FRAC_BITS - 8;
    localparam int PW  = 17 + K;
    localparam int WW  = 16 + K;
    localparam int DW  = PW + 1;
    localparam int EXW = ((COORD_WIDTH > WW) ? COORD_WIDTH : WW) + 1;
    localparam int QB  = pgth_pkg::QUOT_WIDTH;

    logic [15:0]         w;
    logic [15:0]         s;
    logic signed [15:0]  org;
    logic [PW-1:0]       period;
    logic [WW-1:0]       wsc;
    logic signed [EXW-1:0] e_c;
    logic [EXW-1:0]      mag_c;

    assign w      = axis_cfg[15:0];
    assign s      = axis_cfg[31:16];
    assign org    = $signed(axis_cfg[47:32]);
    assign period = PW'({1'b0, w} + {1'b0, s}) << K;
    assign wsc    = WW'(w) << K;
    assign e_c    = EXW'(coord) - (EXW'(org) <<< K);
    assign mag_c  = e_c[EXW-1] ? EXW'(-e_c) : EXW'(e_c);

    // distance is symmetric, so the magnitude of the offset is reduced
    logic [EXW-1:0] mag_reg [0:EXW];
    logic [PW-1:0]  rem_reg [0:EXW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= mag_c;
            rem_reg[0] <= '0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < EXW; gi++)
        begin : g_mod
            logic [PW:0] trial;
            assign trial = {rem_reg[gi], mag_reg[gi][EXW-1-gi]};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    mag_reg[gi+1] <= mag_reg[gi];
                    if (trial >= {1'b0, period})
                        rem_reg[gi+1] <= PW'(trial - {1'b0, period});
                    else
                        rem_reg[gi+1] <= PW'(trial);
                end
            end
        end
    endgenerate

    logic [PW-1:0] comp_c;
    logic [PW-1:0] dist_c;
    logic [DW-1:0] two_a_c;
    logic          hit_c;

    assign comp_c  = period - rem_reg[EXW];
    assign dist_c  = (rem_reg[EXW] < comp_c) ? rem_reg[EXW] : comp_c;
    assign two_a_c = {dist_c, 1'b0};
    assign hit_c   = (w != 16'd0) && (two_a_c <= DW'(wsc));

    logic [DW-1:0] dr_reg [0:QB];
    logic [QB-1:0] qr_reg [0:QB];
    logic          hr_reg [0:QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_reg[0] <= two_a_c;
            qr_reg[0] <= '0;
            hr_reg[0] <= hit_c;
        end
    end

    // one quotient bit of 2a * 2^24 / width per stage
    generate
        for (gi = 0; gi < QB; gi++)
        begin : g_div
            logic [DW-1:0] t;
            logic          ge;
            assign t  = (gi == 0) ? dr_reg[gi] : (dr_reg[gi] << 1);
            assign ge = (t >= DW'(wsc));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dr_reg[gi+1] <= ge ? (t - DW'(wsc)) : t;
                    qr_reg[gi+1] <= {qr_reg[gi][QB-2:0], ge};
                    hr_reg[gi+1] <= hr_reg[gi];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res.hit <= hr_reg[QB];
            res.sq  <= pgth_pkg::SQ_WIDTH'(qr_reg[QB]) * pgth_pkg::SQ_WIDTH'(qr_reg[QB]);
        end
    end

endmodule

// ===== hw/rtl/pgth_merge.sv =====
// merges the three lane results according to the grid mode
module pgth_merge (
    input  logic                  clk,
    input  logic                  en,
    input  pgth_pkg::grid_mode_t  mode,
    input  pgth_pkg::lane_res_t   lx,
    input  pgth_pkg::lane_res_t   ly,
    input  pgth_pkg::lane_res_t   lz,
    output logic                  on_grid
);

    logic [pgth_pkg::SUM_WIDTH-1:0] sum_reg;
    logic [2:0]                     h_reg;
    logic                           on_grid_reg;
    logic                           inside_c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= pgth_pkg::SUM_WIDTH'(lx.sq) + pgth_pkg::SUM_WIDTH'(ly.sq)
                     + pgth_pkg::SUM_WIDTH'(lz.sq);
            h_reg   <= {lz.hit, ly.hit, lx.hit};
        end
    end

    assign inside_c = (sum_reg <= (pgth_pkg::SUM_WIDTH'(1) << (2 * pgth_pkg::DOT_FRAC_BITS)));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (mode)
                pgth_pkg::MODE_PLANE: on_grid_reg <= |h_reg;
                pgth_pkg::MODE_LINE:  on_grid_reg <= (h_reg[0] & h_reg[1])
                                                   | ((h_reg[0] | h_reg[1]) & h_reg[2]);
                pgth_pkg::MODE_CUBE:  on_grid_reg <= &h_reg;
                pgth_pkg::MODE_DOT:   on_grid_reg <= (&h_reg) & inside_c;
                default:              on_grid_reg <= 1'b0;
            endcase
        end
    end

    assign on_grid = on_grid_reg;

endmodule

// ===== hw/rtl/procedural_grid_texture_hit.sv =====
// Procedural grid texture hit test: one point per cycle when the output is not stalled.
// Each item passes a pipeline with one modulo stage per bit of the extended offset width,
// max(COORD_WIDTH, COORD_FRAC_BITS + 8) + 1 (33 bits at the default Q16.16), on each of
// three axis lanes, then 25 divide stages for the dot ratio, a squarer and a two-stage
// merge. The whole pipeline holds while a result is stalled. The user must write
// configuration registers only while idle; the block itself does not enforce this.
module procedural_grid_texture_hit #(
    parameter int COORD_WIDTH     = pgth_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = pgth_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [COORD_WIDTH-1:0]           point_x,
    input  logic signed [COORD_WIDTH-1:0]           point_y,
    input  logic signed [COORD_WIDTH-1:0]           point_z,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    on_grid,
    input  logic                                    cfg_we,
    input  logic [pgth_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pgth_pkg::REG_WIDTH-1:0]          cfg_data
);

    localparam int WW  = COORD_FRAC_BITS + 8;
    localparam int EXW = ((COORD_WIDTH > WW) ? COORD_WIDTH : WW) + 1;
    localparam int N   = EXW + 30;

    pgth_pkg::grid_mode_t              mode_reg;
    logic [pgth_pkg::REG_WIDTH-1:0]    ax_reg;
    logic [pgth_pkg::REG_WIDTH-1:0]    ay_reg;
    logic [pgth_pkg::REG_WIDTH-1:0]    az_reg;
    logic [N-1:0]                      vld_reg;
    logic                              en;
    pgth_pkg::lane_res_t               rx;
    pgth_pkg::lane_res_t               ry;
    pgth_pkg::lane_res_t               rz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pgth_pkg::MODE_PLANE;
            ax_reg   <= '0;
            ay_reg   <= '0;
            az_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pgth_pkg::IDX_GRID_MODE: mode_reg <= pgth_pkg::grid_mode_t'(cfg_data[1:0]);
                pgth_pkg::IDX_AXIS_X:    ax_reg   <= cfg_data;
                pgth_pkg::IDX_AXIS_Y:    ay_reg   <= cfg_data;
                pgth_pkg::IDX_AXIS_Z:    az_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign en        = !vld_reg[N-1] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = vld_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    pgth_lane #(.COORD_WIDTH(COORD_WIDTH), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_x (
        .clk(clk), .en(en), .axis_cfg(ax_reg), .coord(point_x), .res(rx)
    );
    pgth_lane #(.COORD_WIDTH(COORD_WIDTH), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_y (
        .clk(clk), .en(en), .axis_cfg(ay_reg), .coord(point_y), .res(ry)
    );
    pgth_lane #(.COORD_WIDTH(COORD_WIDTH), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_z (
        .clk(clk), .en(en), .axis_cfg(az_reg), .coord(point_z), .res(rz)
    );

    pgth_merge u_merge (
        .clk(clk), .en(en), .mode(mode_reg), .lx(rx), .ly(ry), .lz(rz), .on_grid(on_grid)
    );

`ifndef SYNTH
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output free");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(on_grid)))
        else $error("stalled result changed");
    a_no_result_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == '0) |=> !out_valid)
        else $error("result from empty pipeline");
`endif

endmodule

// ===== bench/tb_procedural_grid_texture_hit.sv =====
// testbench for the procedural grid texture hit block: predicted hits checked in order
module tb_procedural_grid_texture_hit;
    timeunit 1ns;
    timeprecision 1ps;
    import pgth_pkg::*;

    class hit_scoreboard;
        bit pending_hits[$];
        int errors;
        grid_mode_t mode;
        logic [47:0] axis_reg[3];

        function new();
            errors = 0;
            mode = MODE_PLANE;
            for (int i = 0; i < 3; i++)
                axis_reg[i] = '0;
        endfunction

        // axis hit test; returns 2*distance and the scaled width
        function bit axis_test(logic [47:0] r, logic signed [31:0] c,
                               output longint unsigned two_a, output longint unsigned wsc);
            longint unsigned w;
            longint unsigned s;
            longint org;
            longint period;
            longint e;
            longint rem;
            longint a;
            w = r[15:0];
            s = r[31:16];
            org = longint'($signed(r[47:32]));
            two_a = 0;
            wsc = 1;
            if (w == 0)
                return 0;
            period = longint'((w + s) << 8);
            e = longint'(c) - org * 256;
            rem = e % period;
            if (rem < 0)
                rem += period;
            a = rem;
            if (period - rem < a)
                a = period - rem;
            two_a = longint'(a) * 2;
            wsc = w << 8;
            return two_a <= wsc;
        endfunction

        function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
            longint unsigned ta[3];
            longint unsigned ws[3];
            bit h[3];
            bit hit;
            longint unsigned q;
            longint unsigned sum;
            h[0] = axis_test(axis_reg[0], px, ta[0], ws[0]);
            h[1] = axis_test(axis_reg[1], py, ta[1], ws[1]);
            h[2] = axis_test(axis_reg[2], pz, ta[2], ws[2]);
            hit = 0;
            case (mode)
                MODE_PLANE: hit = h[0] || h[1] || h[2];
                MODE_LINE:  hit = (h[0] && h[1]) || ((h[0] || h[1]) && h[2]);
                MODE_CUBE:  hit = h[0] && h[1] && h[2];
                default:
                begin
                    if (h[0] && h[1] && h[2])
                    begin
                        sum = 0;
                        for (int i = 0; i < 3; i++)
                        begin
                            q = (ta[i] << DOT_FRAC_BITS) / ws[i];
                            sum += q * q;
                        end
                        hit = sum <= (64'd1 << (2 * DOT_FRAC_BITS));
                    end
                end
            endcase
            pending_hits.push_back(hit);
        endfunction

        function void check_hit(logic got);
            bit want;
            if (pending_hits.size() == 0)
            begin
                $error("on_grid: no item expected, actual %0b", got);
                errors++;
                return;
            end
            want = pending_hits.pop_front();
            if (got !== want)
            begin
                $error("on_grid: expected %0b actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [31:0] point_x = 0;
    logic signed [31:0] point_y = 0;
    logic signed [31:0] point_z = 0;
    logic out_valid;
    logic out_stall = 0;
    logic on_grid;
    logic cfg_we = 0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [REG_WIDTH-1:0] cfg_data = '0;

    hit_scoreboard board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 2000000;

    procedural_grid_texture_hit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_stall(out_stall), .on_grid(on_grid),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_procedural_grid_texture_hit: done, errors");
            $finish;
        end
    end

    // result side: check, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_hit(on_grid);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [REG_WIDTH-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == IDX_GRID_MODE)
            board.mode = grid_mode_t'(val[1:0]);
        else if (idx <= IDX_AXIS_Z)
            board.axis_reg[idx - 1] = val;
        @(posedge clk);
    endtask

    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_point(px, py, pz);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.pending_hits.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_axis();
        logic [15:0] w;
        logic [15:0] s;
        logic [15:0] o;
        // mostly small periods so that hits are common
        w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1024));
        s = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
        o = 16'($urandom);
        if ($urandom_range(15) == 0)
            w = 0;
        return {o, s, w};
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return 32'($urandom);
            1: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
        endcase
    endfunction

    initial
    begin
        logic signed [31:0] ext[4];
        board = new();
        ext[0] = 32'sh7fffffff;
        ext[1] = 32'sh80000000;
        ext[2] = 0;
        ext[3] = -1;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset config (zero widths), then each mode with extremes
        send_point(0, 0, 0);
        send_point(ext[0], ext[1], ext[3]);
        drain();
        write_reg(IDX_AXIS_X, 48'h0000_0000_0100);
        write_reg(IDX_AXIS_Y, 48'hFFFF_FFFF_FFFF);
        write_reg(IDX_AXIS_Z, 48'h8000_0300_0080);
        write_reg(3'd5, 48'h1234_5678_9abc);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(IDX_GRID_MODE, 48'(m) | 48'hFFFF_FFFF_FFFC);
            for (int i = 0; i < 4; i++)
                send_point(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
            send_point(32'sh0000_0080, 32'sh0000_7f00, 32'sh8000_0040);
            drain();
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 80 : 0;
            recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 7 : 0;
            for (int blk = 0; blk < 8; blk++)
            begin
                write_reg(IDX_GRID_MODE, 48'($urandom_range(3)));
                write_reg(IDX_AXIS_X, rand_axis());
                write_reg(IDX_AXIS_Y, rand_axis());
                write_reg(IDX_AXIS_Z, rand_axis());
                for (int n = 0; n < 80; n++)
                    send_point(rand_coord(), rand_coord(), rand_coord());
                drain();
            end
        end

        if (board.errors == 0 && board.pending_hits.size() == 0)
            $display("tb_procedural_grid_texture_hit: done, clean");
        else
            $display("tb_procedural_grid_texture_hit: done, errors");
        $finish;
    end
endmodule

// ===== procedural_grid_texture_hit.f =====
hw/rtl/pgth_pkg.sv
hw/rtl/pgth_lane.sv
hw/rtl/pgth_merge.sv
hw/rtl/procedural_grid_texture_hit.sv
bench/tb_procedural_grid_texture_hit.sv
